@@ rtl/core/sercp_pkg.sv @@
// Shared types and constants for the serial receive character processor.
// Used by the channel interfaces, the front, queue, back and top level.
package sercp_pkg;

  localparam int BYTE_W     = 8;
  localparam int CHAR_W     = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int QDEPTH_DEF = 2;

  // register indexes (word address bits)
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_STOP  = 2'd2;

  // bit positions in the mode register
  localparam int F_IXON   = 0;
  localparam int F_IXANY  = 1;
  localparam int F_ISTRIP = 2;
  localparam int F_PARMRK = 3;
  localparam int F_INPCK  = 4;
  localparam int F_IGNPAR = 5;
  localparam int F_IGNBRK = 6;
  localparam int F_BRKINT = 7;

  localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hFF;
  localparam logic [CHAR_W-1:0] START_RST = 7'd17;
  localparam logic [CHAR_W-1:0] STOP_RST  = 7'd19;

  typedef enum logic [1:0] {
    FLOW_NONE    = 2'd0,
    FLOW_RESUME  = 2'd1,
    FLOW_SUSPEND = 2'd2
  } flow_t;

  typedef struct packed {
    logic [BYTE_W-1:0] mode;
    logic [CHAR_W-1:0] start_ch;
    logic [CHAR_W-1:0] stop_ch;
  } cfg_t;

  // one classified input: up to three bytes to emit
  typedef struct packed {
    logic [2:0][BYTE_W-1:0] bytes;
    logic [1:0]             last_idx;
    logic                   bvalid;
    logic                   brk;
    flow_t                  flow;
    logic                   stopped;
  } entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              brk;
    flow_t             flow;
    logic              stopped;
  } item_t;

endpackage

@@ rtl/core/sercp_if.sv @@
// Valid/ready channel interfaces for received bytes and result beats.
// Depends on sercp_pkg for field widths.
interface sercp_in_if import sercp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              parity_error;
  logic              overrun_error;
  logic              framing_error;

  modport source (output valid, rx_byte, parity_error, overrun_error, framing_error,
                  input ready);
  modport sink   (input valid, rx_byte, parity_error, overrun_error, framing_error,
                  output ready);
endinterface

interface sercp_out_if import sercp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              last_of_run;
  logic              break_signal;
  logic [1:0]        flow_event;
  logic              output_stopped_now;

  modport source (output valid, out_byte, byte_valid, last_of_run, break_signal,
                  flow_event, output_stopped_now, input ready);
  modport sink   (input valid, out_byte, byte_valid, last_of_run, break_signal,
                  flow_event, output_stopped_now, output ready);
endinterface

@@ rtl/core/sercp_front.sv @@
// Front end: accepts received bytes, applies flow control and error rules,
// and pushes one classified entry per byte. Depends on sercp_pkg, sercp_in_if.
module sercp_front import sercp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  sercp_in_if.sink        in_ch,
  input  logic            q_full,
  output logic            push,
  output entry_t          push_entry
);

  logic stopped_r, stopped_nxt;
  logic [CHAR_W-1:0] low7;
  logic is_start, is_stop, consumed, err, drop, brk;
  flow_t flow;
  logic [BYTE_W-1:0] c;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign c           = in_ch.rx_byte;
  assign low7        = c[CHAR_W-1:0];
  assign is_start    = (low7 == cfg.start_ch);
  assign is_stop     = (low7 == cfg.stop_ch);

  always_comb begin
    stopped_nxt = stopped_r;
    flow        = FLOW_NONE;
    if (cfg.mode[F_IXON]) begin
      if (stopped_r) begin
        if (is_start || cfg.mode[F_IXANY]) begin
          stopped_nxt = 1'b0;
          flow        = FLOW_RESUME;
        end
      end else if (is_stop) begin
        stopped_nxt = 1'b1;
        flow        = FLOW_SUSPEND;
      end
    end
  end

  assign consumed = cfg.mode[F_IXON] && (is_start || is_stop);
  assign err = (in_ch.parity_error && cfg.mode[F_INPCK]) || in_ch.overrun_error ||
               in_ch.framing_error;

  always_comb begin
    drop = 1'b0;
    brk  = 1'b0;
    if (c == '0) begin
      if (cfg.mode[F_IGNBRK]) begin
        drop = 1'b1;
      end else if (cfg.mode[F_BRKINT]) begin
        drop = 1'b1;
        brk  = 1'b1;
      end
    end else if (cfg.mode[F_IGNPAR]) begin
      drop = 1'b1;
    end
  end

  always_comb begin
    push_entry          = '0;
    push_entry.flow     = flow;
    push_entry.stopped  = stopped_nxt;
    if (!consumed) begin
      if (err) begin
        push_entry.brk = brk;
        if (!drop) begin
          push_entry.bvalid = 1'b1;
          if (cfg.mode[F_PARMRK]) begin
            push_entry.bytes[0] = MARK_BYTE;
            push_entry.bytes[2] = c;
            push_entry.last_idx = 2'd2;
          end
        end
      end else begin
        push_entry.bvalid = 1'b1;
        if (cfg.mode[F_ISTRIP]) begin
          push_entry.bytes[0] = {1'b0, low7};
        end else if (c == MARK_BYTE && cfg.mode[F_PARMRK]) begin
          push_entry.bytes[0] = MARK_BYTE;
          push_entry.bytes[1] = MARK_BYTE;
          push_entry.last_idx = 2'd1;
        end else begin
          push_entry.bytes[0] = c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
    end else if (push) begin
      stopped_r <= stopped_nxt;
    end
  end

endmodule

@@ rtl/core/sercp_queue.sv @@
// Short register queue of classified entries between front and back.
// Depends on sercp_pkg for the entry type.
module sercp_queue import sercp_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

@@ rtl/core/sercp_back.sv @@
// Back end: walks the head entry one byte per beat into the output register.
// Depends on sercp_pkg and sercp_out_if.
module sercp_back import sercp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     head,
  input  logic       empty,
  output logic       pop,
  sercp_out_if.source out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  item_t      item_r, item_nxt;
  logic       load, at_last;

  assign load    = !empty && (!out_valid_r || out_ch.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    item_nxt            = item_r;
    out_valid_nxt       = out_valid_r && !out_ch.ready;
    idx_nxt             = idx_r;
    if (load) begin
      out_valid_nxt       = 1'b1;
      item_nxt.out_byte   = head.bytes[idx_r];
      item_nxt.byte_valid = head.bvalid;
      item_nxt.last       = at_last;
      item_nxt.stopped    = head.stopped;
      // break and flow ride only on the first beat
      item_nxt.brk        = (idx_r == 2'd0) ? head.brk : 1'b0;
      item_nxt.flow       = (idx_r == 2'd0) ? head.flow : FLOW_NONE;
      idx_nxt             = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.out_byte           = item_r.out_byte;
  assign out_ch.byte_valid         = item_r.byte_valid;
  assign out_ch.last_of_run        = item_r.last;
  assign out_ch.break_signal       = item_r.brk;
  assign out_ch.flow_event         = item_r.flow;
  assign out_ch.output_stopped_now = item_r.stopped;

`ifndef SYNTHESIS
  a_break_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && item_r.brk |-> item_r.last && !item_r.byte_valid)
    else $error("break beat must be a lone empty beat");
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !item_r.byte_valid |-> item_r.last && item_r.out_byte == '0)
    else $error("empty beat must be last and zero");
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && !item_r.last |=> out_valid_r)
    else $error("run interrupted before its last beat");
`endif

endmodule

@@ rtl/core/serial_rx_char_input_processing.sv @@
// Serial receive character processor. One received byte is accepted per clock
// while the entry queue has room; each byte produces one to three result beats
// (three for a parity-marked error byte, two for a doubled 0377), and the output
// register sends one beat per clock while the sink is ready. An accepted byte is
// written into the entry queue and then loaded into the output register. The
// start/stop characters, the break and the error rules come from the mode, start
// and stop character registers, written over the APB port at byte addresses 0, 4
// and 8.
module serial_rx_char_input_processing import sercp_pkg::*; #(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sercp_in_if.sink              in_ch,
  sercp_out_if.source           out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t   cfg_r, cfg_nxt;
  logic   wr_en;
  logic   push, pop, q_full, q_empty;
  entry_t push_entry, head;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_MODE:  cfg_nxt.mode     = cfg_pwdata[BYTE_W-1:0];
        REG_START: cfg_nxt.start_ch = cfg_pwdata[CHAR_W-1:0];
        REG_STOP:  cfg_nxt.stop_ch  = cfg_pwdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MODE:  cfg_prdata = CFG_DATA_W'(cfg_r.mode);
      REG_START: cfg_prdata = CFG_DATA_W'(cfg_r.start_ch);
      REG_STOP:  cfg_prdata = CFG_DATA_W'(cfg_r.stop_ch);
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= '0;
      cfg_r.start_ch <= START_RST;
      cfg_r.stop_ch  <= STOP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sercp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  sercp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  sercp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ tb/sv/serial_rx_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the serial receive character processor: follows the APB writes,
// predicts the result beats of every accepted received character and checks them.
// Depends on sercp_pkg and the sercp_in_if / sercp_out_if channel interfaces.
module serial_rx_checker import sercp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sercp_in_if                   in_mon,
  sercp_out_if                  out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int unsigned           fail_count,
  output int unsigned           beats_owed,
  output int unsigned           beats_seen
);

  logic [BYTE_W-1:0] mode_q;
  logic [CHAR_W-1:0] start_q;
  logic [CHAR_W-1:0] stop_q;
  logic              stopped_q;
  item_t             owed_beats[$];
  int unsigned       fails;
  int unsigned       seen;

  // Apply the input rules to one received character and queue its beats.
  function automatic void classify_char(input logic [BYTE_W-1:0] c, input logic pe,
                                        input logic oe, input logic fe);
    logic [BYTE_W-1:0] emit[3];
    int                n;
    logic              brk;
    flow_t             flow;
    logic              eaten;
    logic              bad;
    logic              drop;
    logic [CHAR_W-1:0] low7;
    item_t             it;
    n     = 0;
    brk   = 1'b0;
    flow  = FLOW_NONE;
    eaten = 1'b0;
    drop  = 1'b0;
    low7  = c[CHAR_W-1:0];
    if (mode_q[F_IXON]) begin
      if (stopped_q) begin
        if (low7 == start_q || mode_q[F_IXANY]) begin
          stopped_q = 1'b0;
          flow      = FLOW_RESUME;
        end
      end else if (low7 == stop_q) begin
        stopped_q = 1'b1;
        flow      = FLOW_SUSPEND;
      end
      if (low7 == start_q || low7 == stop_q) eaten = 1'b1;
    end
    if (!eaten) begin
      bad = (pe && mode_q[F_INPCK]) || oe || fe;
      if (bad) begin
        if (c == '0) begin
          if (mode_q[F_IGNBRK]) drop = 1'b1;
          else if (mode_q[F_BRKINT]) begin
            brk  = 1'b1;
            drop = 1'b1;
          end
        end else if (mode_q[F_IGNPAR]) begin
          drop = 1'b1;
        end
        if (!drop) begin
          if (mode_q[F_PARMRK]) begin
            emit[0] = MARK_BYTE;
            emit[1] = '0;
            emit[2] = c;
            n = 3;
          end else begin
            emit[0] = '0;
            n = 1;
          end
        end
      end else if (mode_q[F_ISTRIP]) begin
        emit[0] = {1'b0, low7};
        n = 1;
      end else if (c == MARK_BYTE && mode_q[F_PARMRK]) begin
        emit[0] = MARK_BYTE;
        emit[1] = MARK_BYTE;
        n = 2;
      end else begin
        emit[0] = c;
        n = 1;
      end
    end
    if (n == 0) begin
      it = '{out_byte: '0, byte_valid: 1'b0, last: 1'b1, brk: brk, flow: flow,
             stopped: stopped_q};
      owed_beats.push_back(it);
    end else begin
      for (int k = 0; k < n; k++) begin
        it.out_byte   = emit[k];
        it.byte_valid = 1'b1;
        it.last       = (k == n - 1);
        it.brk        = (k == 0) ? brk : 1'b0;
        it.flow       = (k == 0) ? flow : FLOW_NONE;
        it.stopped    = stopped_q;
        owed_beats.push_back(it);
      end
    end
  endfunction

  always @(posedge clk) begin
    item_t act;
    item_t exp_beat;
    if (!rst_n) begin
      mode_q    = '0;
      start_q   = START_RST;
      stop_q    = STOP_RST;
      stopped_q = 1'b0;
      owed_beats.delete();
      fails     = 0;
      seen      = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_MODE:  mode_q  = cfg_pwdata[BYTE_W-1:0];
          REG_START: start_q = cfg_pwdata[CHAR_W-1:0];
          REG_STOP:  stop_q  = cfg_pwdata[CHAR_W-1:0];
          default: ;
        endcase
      end
      // check the outgoing beat before queuing new ones
      if (out_mon.valid && out_mon.ready) begin
        act.out_byte   = out_mon.out_byte;
        act.byte_valid = out_mon.byte_valid;
        act.last       = out_mon.last_of_run;
        act.brk        = out_mon.break_signal;
        act.flow       = flow_t'(out_mon.flow_event);
        act.stopped    = out_mon.output_stopped_now;
        seen++;
        if (owed_beats.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none,", $time);
          $display("%0t:   got byte=%02h bv=%b last=%b brk=%b flow=%0d stop=%b",
                   $time, act.out_byte, act.byte_valid, act.last, act.brk, act.flow,
                   act.stopped);
        end else begin
          exp_beat = owed_beats.pop_front();
          if (act.out_byte !== exp_beat.out_byte || act.byte_valid !== exp_beat.byte_valid ||
              act.last !== exp_beat.last || act.brk !== exp_beat.brk ||
              act.flow !== exp_beat.flow || act.stopped !== exp_beat.stopped) begin
            fails++;
            $display("%0t: beat mismatch, expected byte=%02h bv=%b last=%b brk=%b flow=%0d stop=%b",
                     $time, exp_beat.out_byte, exp_beat.byte_valid, exp_beat.last,
                     exp_beat.brk, exp_beat.flow, exp_beat.stopped);
            $display("%0t:                  got byte=%02h bv=%b last=%b brk=%b flow=%0d stop=%b",
                     $time, act.out_byte, act.byte_valid, act.last, act.brk, act.flow,
                     act.stopped);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        classify_char(in_mon.rx_byte, in_mon.parity_error, in_mon.overrun_error,
                      in_mon.framing_error);
    end
    fail_count <= fails;
    beats_owed <= owed_beats.size();
    beats_seen <= seen;
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the serial receive character processor testbench: clock, reset, APB
// writes, received-character stimulus and result-side backpressure, plus the verdict.
// Depends on sercp_pkg, the channel interfaces, the block and serial_rx_checker.
module tb_top;
  import sercp_pkg::*;

  localparam int          LIMIT       = 200000;
  localparam int          LONG_HOLD   = 150;
  localparam int          RAND_PHASES = 9;
  localparam int          PHASE_CHARS = 20;
  localparam logic [7:0]  M_IXON      = 8'b1 << F_IXON;
  localparam logic [7:0]  M_IXANY     = 8'b1 << F_IXANY;
  localparam logic [7:0]  M_ISTRIP    = 8'b1 << F_ISTRIP;
  localparam logic [7:0]  M_PARMRK    = 8'b1 << F_PARMRK;
  localparam logic [7:0]  M_INPCK     = 8'b1 << F_INPCK;
  localparam logic [7:0]  M_IGNPAR    = 8'b1 << F_IGNPAR;
  localparam logic [7:0]  M_BRKINT    = 8'b1 << F_BRKINT;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int unsigned           fail_count;
  int unsigned           beats_owed;
  int unsigned           beats_seen;
  int unsigned           cycles;
  int unsigned           chars_sent;
  int unsigned           settings_used;
  logic [CHAR_W-1:0]     cur_start;
  logic [CHAR_W-1:0]     cur_stop;
  bit                    quiet_tx;
  bit                    quiet_rx;
  bit                    hold_req;

  sercp_in_if  in_ch();
  sercp_out_if out_ch();

  serial_rx_char_input_processing DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  serial_rx_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .beats_owed  (beats_owed),
    .beats_seen  (beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: random stall bursts, or one long hold-off when asked.
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (quiet_rx || $urandom_range(0, 5) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx) << 2;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [7:0] mode, input logic [6:0] st, input logic [6:0] sp);
    cfg_write(REG_MODE, CFG_DATA_W'(mode));
    cfg_write(REG_START, CFG_DATA_W'(st));
    cfg_write(REG_STOP, CFG_DATA_W'(sp));
    cur_start = st;
    cur_stop  = sp;
    settings_used++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic pe, input logic oe,
                           input logic fe);
    if (!quiet_tx && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.rx_byte       <= c;
    in_ch.parity_error  <= pe;
    in_ch.overrun_error <= oe;
    in_ch.framing_error <= fe;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
  endtask

  // Drop valid and wait until every owed beat is out, then let the pipe settle.
  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return {1'($urandom_range(0, 1)), cur_start};
      2, 3:    return {1'($urandom_range(0, 1)), cur_stop};
      4:       return 8'h00;
      5:       return 8'hFF;
      6:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [6:0] pick_flow_char(input logic [6:0] dflt);
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return dflt;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    logic [7:0] mode;
    chars_sent          = 0;
    settings_used       = 1;
    cur_start           = START_RST;
    cur_stop            = STOP_RST;
    quiet_tx            = 1'b0;
    quiet_rx            = 1'b0;
    hold_req            = 1'b0;
    rst_n              <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.rx_byte      <= '0;
    in_ch.parity_error <= 1'b0;
    in_ch.overrun_error <= 1'b0;
    in_ch.framing_error <= 1'b0;
    out_ch.ready       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no flags, parity alone ignored, break becomes a plain zero
    send_char(8'h00, 1'b0, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0, 1'b1);
    send_char(8'h41, 1'b1, 1'b0, 1'b0);
    drain();

    // flow control with parity marking
    set_mode(M_IXON | M_PARMRK | M_INPCK, START_RST, STOP_RST);
    send_char(8'h13, 1'b0, 1'b0, 1'b0);
    send_char(8'h93, 1'b0, 1'b0, 1'b0);
    send_char(8'h41, 1'b0, 1'b0, 1'b0);
    send_char(8'h11, 1'b0, 1'b0, 1'b0);
    send_char(8'h11, 1'b0, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0, 1'b0);
    send_char(8'h41, 1'b1, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b1, 1'b0);
    drain();

    // any character resumes, seven-bit strip, extreme flow characters
    set_mode(M_IXON | M_IXANY | M_ISTRIP | M_BRKINT, 7'd0, 7'd127);
    send_char(8'h7F, 1'b0, 1'b0, 1'b0);
    send_char(8'hC5, 1'b0, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0, 1'b1);
    send_char(8'hFF, 1'b0, 1'b0, 1'b0);
    send_char(8'h80, 1'b0, 1'b0, 1'b0);
    send_char(8'h2A, 1'b0, 1'b0, 1'b1);
    drain();

    set_mode(8'hFF, START_RST, STOP_RST);
    send_char(8'h00, 1'b0, 1'b0, 1'b1);
    send_char(8'h55, 1'b1, 1'b0, 1'b0);
    send_char(8'h13, 1'b0, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0, 1'b0);
    drain();

    // break signalled upstream; a write past the last register goes nowhere
    set_mode(M_BRKINT | M_IGNPAR | M_INPCK, 7'd127, 7'd0);
    cfg_write(2'd3, 32'hFFFF_FFFF);
    send_char(8'h00, 1'b0, 1'b0, 1'b1);
    send_char(8'h00, 1'b1, 1'b0, 1'b0);
    send_char(8'h80, 1'b0, 1'b1, 1'b0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       mode = 8'h00;
        1:       mode = 8'hFF;
        2:       mode = 8'($urandom_range(0, 255)) | M_IXON;
        default: mode = 8'($urandom_range(0, 255));
      endcase
      set_mode(mode, pick_flow_char(START_RST), pick_flow_char(STOP_RST));
      if ($urandom_range(0, 3) == 0) cfg_write(2'd3, 32'($urandom()));
      quiet_tx = (p == RAND_PHASES - 1) || ($urandom_range(0, 4) == 0);
      quiet_rx = (p == RAND_PHASES - 1) || ($urandom_range(0, 4) == 0);
      if (p == 3) begin
        // back up the result side and keep offering characters
        quiet_tx = 1'b1;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_CHARS; i++)
        send_char(pick_char(), $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0,
                  $urandom_range(0, 5) == 0);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d received characters under %0d register settings,",
             chars_sent, settings_used);
    $display("with %0d result beats checked against the prediction.", beats_seen);
    if (fail_count == 0 && beats_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
